// ===== src/gdw_pkg.sv =====
`timescale 1ns / 1ps

package gdw_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 7;
    localparam int CMD_W         = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DFS   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BFS   = 2'd3;

    // Adjacency read address source
    typedef enum logic [1:0] {
        ADJ_A   = 2'd0,
        ADJ_B   = 2'd1,
        ADJ_CUR = 2'd2,
        ADJ_WMQ = 2'd3
    } adj_sel_t;

    typedef struct packed {
        logic     load;        // latch endpoints and walk kind
        logic     clear_graph;
        logic     walk_start;
        logic     start_emit;  // depth-first: start node goes out at once
        logic     adj_rd;
        adj_sel_t adj_sel;
        logic     adj_wr;
        logic     adj_wr_b;    // write row of node_b instead of node_a
        logic     d_push;
        logic     d_pop;
        logic     d_top_load;
        logic     q_rd_head;
        logic     b_cur_load;
        logic     b_row_load;
        logic     b_enq;
        logic     b_emit;
        logic     flush;
    } gdw_cmd_t;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
        logic d_open_nz;
        logic b_open_nz;
        logic depth_one;
        logic b_done;
        logic emit_ok;
        logic out_free;
    } gdw_stat_t;

endpackage

// ===== src/gdw_ctrl.sv =====
`timescale 1ns / 1ps

module gdw_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [gdw_pkg::CMD_W-1:0] command,
    input  gdw_pkg::gdw_stat_t        stat,
    output gdw_pkg::gdw_cmd_t         cmd,
    output logic                      in_stall
);
    import gdw_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_E_RDA   = 13'b0000000000010,
        ST_E_WRA   = 13'b0000000000100,
        ST_E_RDB   = 13'b0000000001000,
        ST_E_WRB   = 13'b0000000010000,
        ST_D_READ  = 13'b0000000100000,
        ST_D_SCAN  = 13'b0000001000000,
        ST_D_POP   = 13'b0000010000000,
        ST_B_FETCH = 13'b0000100000000,
        ST_B_CUR   = 13'b0001000000000,
        ST_B_ROW   = 13'b0010000000000,
        ST_B_ENQ   = 13'b0100000000000,
        ST_FLUSH   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.adj_sel = ADJ_A;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (command)
                        CMD_CLEAR:
                        begin
                            cmd.clear_graph = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            if (stat.a_ok && stat.b_ok)
                            begin
                                state_next = ST_E_RDA;
                            end
                        end
                        CMD_DFS:
                        begin
                            if (stat.a_ok)
                            begin
                                cmd.walk_start = 1'b1;
                                cmd.start_emit = 1'b1;
                                state_next     = ST_D_READ;
                            end
                        end
                        CMD_BFS:
                        begin
                            if (stat.a_ok)
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = ST_B_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_E_RDA:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_sel = ADJ_A;
                state_next  = ST_E_WRA;
            end
            ST_E_WRA:
            begin
                cmd.adj_wr = 1'b1;
                state_next = ST_E_RDB;
            end
            ST_E_RDB:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_sel = ADJ_B;
                state_next  = ST_E_WRB;
            end
            ST_E_WRB:
            begin
                cmd.adj_wr   = 1'b1;
                cmd.adj_wr_b = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_D_READ:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_sel = ADJ_CUR;
                state_next  = ST_D_SCAN;
            end
            ST_D_SCAN:
            begin
                if (stat.d_open_nz)
                begin
                    // push waits for room in the emit path
                    if (stat.emit_ok)
                    begin
                        cmd.d_push = 1'b1;
                        state_next = ST_D_READ;
                    end
                end
                else if (stat.depth_one)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.d_pop  = 1'b1;
                    state_next = ST_D_POP;
                end
            end
            ST_D_POP:
            begin
                cmd.d_top_load = 1'b1;
                state_next     = ST_D_READ;
            end
            ST_B_FETCH:
            begin
                cmd.q_rd_head = 1'b1;
                state_next    = ST_B_CUR;
            end
            ST_B_CUR:
            begin
                cmd.b_cur_load = 1'b1;
                cmd.adj_rd     = 1'b1;
                cmd.adj_sel    = ADJ_WMQ;
                state_next     = ST_B_ROW;
            end
            ST_B_ROW:
            begin
                cmd.b_row_load = 1'b1;
                state_next     = ST_B_ENQ;
            end
            ST_B_ENQ:
            begin
                if (stat.b_open_nz)
                begin
                    cmd.b_enq = 1'b1;
                end
                else if (stat.emit_ok)
                begin
                    cmd.b_emit = 1'b1;
                    state_next = stat.b_done ? ST_FLUSH : ST_B_FETCH;
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/gdw_dpath.sv =====
`timescale 1ns / 1ps

module gdw_dpath
#(
    parameter int MAX_NODES = gdw_pkg::MAX_NODES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [gdw_pkg::CMD_W-1:0]  command,
    input  logic [gdw_pkg::NODE_W-1:0] node_a,
    input  logic [gdw_pkg::NODE_W-1:0] node_b,
    input  gdw_pkg::gdw_cmd_t          cmd,
    output gdw_pkg::gdw_stat_t         stat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [gdw_pkg::NODE_W-1:0] visited_node,
    output logic                       walk_kind,
    output logic                       last
);
    import gdw_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [MAX_NODES-1:0] ONE_V = MAX_NODES'(1);
    localparam logic [NODE_W-1:0]    MAX_N = NODE_W'(MAX_NODES);

    // adjacency rows, one valid bit per row stands for the cleared state
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] row_q;
    logic                 row_vld_q;
    logic [MAX_NODES-1:0] row_m;

    // shared stack / queue store
    logic [NW-1:0] walk_mem [MAX_NODES];
    logic [NW-1:0] wm_q;

    logic [NW-1:0]        ia_reg;
    logic [NW-1:0]        ib_reg;
    logic                 kind_reg;
    logic [NW-1:0]        cur_reg;
    logic [CW-1:0]        ptr_reg;   // stack depth / queue tail
    logic [CW-1:0]        head_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [MAX_NODES-1:0] b_open_reg;

    logic                 pend_valid_reg;
    logic [NW-1:0]        pend_idx_reg;
    logic                 pend_kind_reg;
    logic                 out_valid_reg;
    logic [NODE_W-1:0]    out_node_reg;
    logic                 out_kind_reg;
    logic                 out_last_reg;

    logic [NW-1:0]        in_ia;
    logic [NW-1:0]        in_ib;
    logic [MAX_NODES-1:0] d_open;
    logic [MAX_NODES-1:0] scan_vec;
    logic [NW-1:0]        scan_idx;
    logic [NW-1:0]        adj_raddr;
    logic [NW-1:0]        adj_waddr;
    logic [MAX_NODES-1:0] adj_wdata;
    logic [NW-1:0]        wm_raddr;
    logic                 wm_we;
    logic [NW-1:0]        wm_waddr;
    logic [NW-1:0]        wm_wdata;
    logic                 emit;
    logic [NW-1:0]        emit_idx;
    logic                 emit_kind;
    logic                 move;
    logic                 out_free;

    assign in_ia = NW'(node_a - NODE_W'(1));
    assign in_ib = NW'(node_b - NODE_W'(1));

    assign row_m    = row_vld_q ? row_q : '0;
    assign d_open   = row_m & ~visited_reg;
    assign scan_vec = kind_reg ? b_open_reg : d_open;

    // lowest set bit
    always_comb
    begin
        scan_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (scan_vec[i])
            begin
                scan_idx = NW'(i);
            end
        end
    end

    always_comb
    begin
        case (cmd.adj_sel)
            ADJ_A:   adj_raddr = ia_reg;
            ADJ_B:   adj_raddr = ib_reg;
            ADJ_CUR: adj_raddr = cur_reg;
            ADJ_WMQ: adj_raddr = wm_q;
            default: adj_raddr = ia_reg;
        endcase
    end

    assign adj_waddr = cmd.adj_wr_b ? ib_reg : ia_reg;
    assign adj_wdata = row_m | (ONE_V << (cmd.adj_wr_b ? ia_reg : ib_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.adj_wr)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (cmd.adj_rd)
        begin
            row_q <= adj_mem[adj_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_vld_q     <= 1'b0;
        end
        else
        begin
            if (cmd.adj_rd)
            begin
                row_vld_q <= row_valid_reg[adj_raddr];
            end
            if (cmd.clear_graph)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.adj_wr)
            begin
                row_valid_reg[adj_waddr] <= 1'b1;
            end
        end
    end

    // walk store: start entry, stack push, queue append
    assign wm_raddr = cmd.q_rd_head ? NW'(head_reg) : NW'(ptr_reg - CW'(2));
    always_comb
    begin
        wm_we    = 1'b0;
        wm_waddr = NW'(ptr_reg);
        wm_wdata = scan_idx;
        if (cmd.walk_start)
        begin
            wm_we    = 1'b1;
            wm_waddr = '0;
            wm_wdata = in_ia;
        end
        else if (cmd.d_push || cmd.b_enq)
        begin
            wm_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            walk_mem[wm_waddr] <= wm_wdata;
        end
        if (cmd.q_rd_head || cmd.d_pop)
        begin
            wm_q <= walk_mem[wm_raddr];
        end
    end

    // walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ia_reg      <= '0;
            ib_reg      <= '0;
            kind_reg    <= 1'b0;
            cur_reg     <= '0;
            ptr_reg     <= '0;
            head_reg    <= '0;
            visited_reg <= '0;
            b_open_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ia_reg   <= in_ia;
                ib_reg   <= in_ib;
                kind_reg <= command[0];
            end
            if (cmd.walk_start)
            begin
                visited_reg <= ONE_V << in_ia;
                cur_reg     <= in_ia;
                ptr_reg     <= CW'(1);
                head_reg    <= '0;
            end
            if (cmd.d_push)
            begin
                visited_reg <= visited_reg | (ONE_V << scan_idx);
                cur_reg     <= scan_idx;
                ptr_reg     <= ptr_reg + CW'(1);
            end
            if (cmd.d_pop)
            begin
                ptr_reg <= ptr_reg - CW'(1);
            end
            if (cmd.d_top_load || cmd.b_cur_load)
            begin
                cur_reg <= wm_q;
            end
            if (cmd.b_row_load)
            begin
                b_open_reg  <= d_open;
                visited_reg <= visited_reg | d_open;
            end
            if (cmd.b_enq)
            begin
                b_open_reg <= b_open_reg & (b_open_reg - ONE_V);
                ptr_reg    <= ptr_reg + CW'(1);
            end
            if (cmd.b_emit)
            begin
                head_reg <= head_reg + CW'(1);
            end
        end
    end

    // emit path: one node held back until its last flag is known
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = cmd.start_emit || cmd.d_push || cmd.b_emit;
    assign emit_idx  = cmd.start_emit ? in_ia : (cmd.d_push ? scan_idx : cur_reg);
    assign emit_kind = cmd.b_emit;
    assign move      = (emit && pend_valid_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pend_idx_reg  <= emit_idx;
            pend_kind_reg <= emit_kind;
        end
        if (move)
        begin
            out_node_reg <= NODE_W'(pend_idx_reg) + NODE_W'(1);
            out_kind_reg <= pend_kind_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visited_node = out_node_reg;
    assign walk_kind    = out_kind_reg;
    assign last         = out_last_reg;

    assign stat.a_ok      = (node_a != '0) && (node_a <= MAX_N);
    assign stat.b_ok      = (node_b != '0) && (node_b <= MAX_N);
    assign stat.d_open_nz = |d_open;
    assign stat.b_open_nz = |b_open_reg;
    assign stat.depth_one = (ptr_reg == CW'(1));
    assign stat.b_done    = (CW'(head_reg + CW'(1)) == ptr_reg);
    assign stat.emit_ok   = !pend_valid_reg || out_free;
    assign stat.out_free  = out_free;

endmodule

// ===== src/graph_dfs_bfs_walker.sv =====
`timescale 1ns / 1ps

// Graph walker over an undirected graph of up to MAX_NODES nodes (1..MAX_NODES).
// Input channel (in_valid / in_stall): one beat carries command, node_a, node_b.
//   clear graph and add edge produce no output; a walk produces one output
//   beat per reachable node, lowest-numbered unvisited neighbor first.
// Output channel (out_valid / out_stall): visited_node, walk_kind (0 depth-
//   first, 1 breadth-first) and last on the final node of a walk.
// The block takes one command at a time: in_stall is high from the accepting
//   edge until the command is finished and its final beat sits in the output
//   register.
// Clear acts in the accepting cycle; add edge then does a read-modify-write of
//   two matrix rows, one row after the other. Depth-first: read the current
//   row, scan it for its lowest unvisited neighbor, then push and emit that
//   node, or pop the stack if none is left. Breadth-first: fetch the queue
//   head, read its row, enqueue its unvisited neighbors one at a time, then
//   emit it. Each walk ends in a flush that drains the held-back final node.
// Reset clears the matrix (per-row valid bits), the visited marks and all
//   handshake state; no sweep is needed, the block is ready right away.
// When out_stall holds the output register full, the walk pauses at its next
//   emitted node and resumes once the beat is taken; nothing is dropped.

module graph_dfs_bfs_walker
#(
    parameter int MAX_NODES = gdw_pkg::MAX_NODES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [gdw_pkg::CMD_W-1:0]  command,
    input  logic [gdw_pkg::NODE_W-1:0] node_a,
    input  logic [gdw_pkg::NODE_W-1:0] node_b,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [gdw_pkg::NODE_W-1:0] visited_node,
    output logic                       walk_kind,
    output logic                       last
);
    import gdw_pkg::*;

    gdw_cmd_t  cmd;
    gdw_stat_t stat;

    // sequencer: command decode, walk loop control, emit pacing
    gdw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // matrix, visited marks, stack/queue store, scan and output register
    gdw_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .node_a       (node_a),
        .node_b       (node_b),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .visited_node (visited_node),
        .walk_kind    (walk_kind),
        .last         (last)
    );

endmodule
